/* design/csr_common_neighbor_counter_defines.svh */
// Assertion macros shared by the common-neighbor counter modules.
`ifndef CSR_COMMON_NEIGHBOR_COUNTER_DEFINES_SVH
`define CSR_COMMON_NEIGHBOR_COUNTER_DEFINES_SVH

// Implication in the same cycle, checked only out of reset
`define CNC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle, checked only out of reset
`define CNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/cnc_pkg.sv */
`default_nettype none

package cnc_pkg;

	// Default store sizes
	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_MAX_EDGES = 16384;

	// Field widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 14;
	localparam int VALUE_W = 15;
	localparam int NODE_W  = 10;
	localparam int NBR_W   = 10;
	localparam int COUNT_W = 11;

	// Input tdata layout, lowest field first
	localparam int ADDR_LSB   = 0;
	localparam int VALUE_LSB  = ADDR_LSB + ADDR_W;
	localparam int SRC_LSB    = VALUE_LSB + VALUE_W;
	localparam int DST_LSB    = SRC_LSB + NODE_W;
	localparam int IN_DATA_W  = ((DST_LSB + NODE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((COUNT_W + 7) / 8) * 8;

	// Command codes carried in the input tuser
	typedef logic [OP_W-1:0] cnc_op_t;
	localparam cnc_op_t OP_LOAD_ROW = 2'd0;
	localparam cnc_op_t OP_LOAD_NBR = 2'd1;
	localparam cnc_op_t OP_QUERY    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_DST,
		ST_BOUNDS,
		ST_MERGE,
		ST_DONE
	} cnc_state_t;

	// Controller to datapath
	typedef struct packed {
		logic wr_row;       // write the row-start store
		logic wr_nbr;       // write the neighbor store
		logic latch_query;  // capture the queried pair
		logic cap_src;      // take source row bounds, read destination row
		logic cap_dst;      // take destination row bounds, clear the count
		logic step;         // one merge step
		logic load_result;  // move the count to the output register
	} cnc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic merge_done;   // one of the two rows is exhausted
	} cnc_status_t;

endpackage

`default_nettype wire

/* design/cnc_ram.sv */
`default_nettype none

module cnc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr0,
	output logic      [WIDTH-1:0] rdata0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata0_q;
	logic [WIDTH-1:0] rdata1_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two registered read ports
	always_ff @(posedge clk) begin
		rdata0_q <= mem_q[raddr0];
		rdata1_q <= mem_q[raddr1];
	end

	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

`default_nettype wire

/* design/cnc_ctrl.sv */
`default_nettype none
`include "csr_common_neighbor_counter_defines.svh"

module cnc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire cnc_pkg::cnc_op_t      in_op,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output cnc_pkg::cnc_cmd_t          cmd,
	input  wire cnc_pkg::cnc_status_t  status
);

	cnc_pkg::cnc_state_t state_q, state_d;
	logic                out_valid_q, out_valid_d;

	// State and output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cnc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = (state_q == cnc_pkg::ST_IDLE);
		case (state_q)
			cnc_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						cnc_pkg::OP_LOAD_ROW: cmd.wr_row = 1'b1;
						cnc_pkg::OP_LOAD_NBR: cmd.wr_nbr = 1'b1;
						cnc_pkg::OP_QUERY: begin
							cmd.latch_query = 1'b1;
							state_d         = cnc_pkg::ST_ROW_DST;
						end
						default: ;
					endcase
				end
			end
			cnc_pkg::ST_ROW_DST: begin
				cmd.cap_src = 1'b1;
				state_d     = cnc_pkg::ST_BOUNDS;
			end
			cnc_pkg::ST_BOUNDS: begin
				cmd.cap_dst = 1'b1;
				state_d     = cnc_pkg::ST_MERGE;
			end
			cnc_pkg::ST_MERGE: begin
				if (status.merge_done) begin
					state_d = cnc_pkg::ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			cnc_pkg::ST_DONE: begin
				// hold the count until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = cnc_pkg::ST_IDLE;
				end
			end
			default: state_d = cnc_pkg::ST_IDLE;
		endcase
	end

	// Output register flag: set on a new result, drop once the transfer is taken
	always_comb begin
		if (cmd.load_result) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	`CNC_ASSERT_NEXT(a_query_starts, clk, arst_n, state_q == cnc_pkg::ST_IDLE && in_valid && in_op == cnc_pkg::OP_QUERY, state_q == cnc_pkg::ST_ROW_DST, "query did not start the row lookup")
	`CNC_ASSERT_NEXT(a_load_stays_idle, clk, arst_n, state_q == cnc_pkg::ST_IDLE && in_valid && in_op != cnc_pkg::OP_QUERY, state_q == cnc_pkg::ST_IDLE, "non-query item left idle")
	`CNC_ASSERT_NEXT(a_result_posted, clk, arst_n, cmd.load_result, out_valid_q && state_q == cnc_pkg::ST_IDLE, "result not posted on finish")

endmodule

`default_nettype wire

/* design/cnc_datapath.sv */
`default_nettype none
`include "csr_common_neighbor_counter_defines.svh"

module cnc_datapath #(
	parameter int MAX_NODES = cnc_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = cnc_pkg::DEF_MAX_EDGES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cnc_pkg::cnc_cmd_t             cmd,
	output cnc_pkg::cnc_status_t               status,
	input  wire logic [cnc_pkg::ADDR_W-1:0]    load_address,
	input  wire logic [cnc_pkg::VALUE_W-1:0]   load_value,
	input  wire logic [cnc_pkg::NODE_W-1:0]    src_node,
	input  wire logic [cnc_pkg::NODE_W-1:0]    dst_node,
	output logic      [cnc_pkg::COUNT_W-1:0]   common_count
);

	localparam int RW = $clog2(MAX_NODES + 1);   // row-start index
	localparam int NW = $clog2(MAX_EDGES);       // neighbor index
	localparam int EW = $clog2(MAX_EDGES + 1);   // edge pointer, holds MAX_EDGES
	localparam logic [31:0] NODES_LIM = 32'(MAX_NODES);
	localparam logic [31:0] EDGES_LIM = 32'(MAX_EDGES);

	logic [31:0]                   waddr_ext;
	logic                          row_we, nbr_we;
	logic [cnc_pkg::NODE_W-1:0]    row_node;
	logic [31:0]                   row_lo_addr, row_hi_addr;
	logic [cnc_pkg::VALUE_W-1:0]   row_lo_data, row_hi_data;
	logic [31:0]                   lo_ext, hi_ext, lo_clamp, hi_clamp;
	logic                          dst_ok, row_ok;
	logic [EW-1:0]                 lo_bound, hi_bound;
	logic [cnc_pkg::NBR_W-1:0]     nbr_a, nbr_b;
	logic                          ids_eq, ids_lt;
	logic [EW-1:0]                 a_q, b_q, ae_q, be_q;
	logic [EW-1:0]                 a_next, b_next, a_d, b_d;
	logic                          src_ok_q;
	logic [cnc_pkg::NODE_W-1:0]    dst_q;
	logic [cnc_pkg::COUNT_W-1:0]   count_q, common_count_q;

	// Store writes, out-of-range addresses dropped
	assign waddr_ext = 32'(load_address);
	assign row_we    = cmd.wr_row && (waddr_ext <= NODES_LIM);
	assign nbr_we    = cmd.wr_nbr && (waddr_ext < EDGES_LIM);

	// Row lookup: source row straight from the input, then the latched destination
	assign row_node    = cmd.cap_src ? dst_q : src_node;
	assign row_lo_addr = 32'(row_node);
	assign row_hi_addr = row_lo_addr + 32'd1;

	cnc_ram #(
		.WIDTH (cnc_pkg::VALUE_W),
		.DEPTH (MAX_NODES + 1)
	) u_row_ram (
		.clk    (clk),
		.we     (row_we),
		.waddr  (waddr_ext[RW-1:0]),
		.wdata  (load_value),
		.raddr0 (row_lo_addr[RW-1:0]),
		.rdata0 (row_lo_data),
		.raddr1 (row_hi_addr[RW-1:0]),
		.rdata1 (row_hi_data)
	);

	cnc_ram #(
		.WIDTH (cnc_pkg::NBR_W),
		.DEPTH (MAX_EDGES)
	) u_nbr_ram (
		.clk    (clk),
		.we     (nbr_we),
		.waddr  (waddr_ext[NW-1:0]),
		.wdata  (load_value[cnc_pkg::NBR_W-1:0]),
		.raddr0 (a_d[NW-1:0]),
		.rdata0 (nbr_a),
		.raddr1 (b_d[NW-1:0]),
		.rdata1 (nbr_b)
	);

	// Row bounds: saturate at the store size, empty row for a node out of range
	assign lo_ext   = 32'(row_lo_data);
	assign hi_ext   = 32'(row_hi_data);
	assign lo_clamp = (lo_ext > EDGES_LIM) ? EDGES_LIM : lo_ext;
	assign hi_clamp = (hi_ext > EDGES_LIM) ? EDGES_LIM : hi_ext;
	assign dst_ok   = (32'(dst_q) < NODES_LIM);
	assign row_ok   = cmd.cap_src ? src_ok_q : dst_ok;
	assign lo_bound = row_ok ? lo_clamp[EW-1:0] : '0;
	assign hi_bound = row_ok ? hi_clamp[EW-1:0] : '0;

	// Merge step: advance both on a match, otherwise the smaller side
	assign ids_eq = (nbr_a == nbr_b);
	assign ids_lt = (nbr_a < nbr_b);
	assign a_next = (ids_eq || ids_lt)  ? a_q + EW'(1) : a_q;
	assign b_next = (ids_eq || !ids_lt) ? b_q + EW'(1) : b_q;

	// Next pointers double as the read addresses, so read data tracks a_q and b_q
	always_comb begin
		if (cmd.cap_src) begin
			a_d = lo_bound;
		end else if (cmd.step) begin
			a_d = a_next;
		end else begin
			a_d = a_q;
		end
		if (cmd.cap_dst) begin
			b_d = lo_bound;
		end else if (cmd.step) begin
			b_d = b_next;
		end else begin
			b_d = b_q;
		end
	end

	assign status.merge_done = !((a_q < ae_q) && (b_q < be_q));

	// Pointers, row ends and the queried pair
	always_ff @(posedge clk) begin
		a_q <= a_d;
		b_q <= b_d;
		if (cmd.cap_src) begin
			ae_q <= hi_bound;
		end
		if (cmd.cap_dst) begin
			be_q <= hi_bound;
		end
		if (cmd.latch_query) begin
			src_ok_q <= (32'(src_node) < NODES_LIM);
			dst_q    <= dst_node;
		end
	end

	// Match count, saturating
	always_ff @(posedge clk) begin
		if (cmd.cap_dst) begin
			count_q <= '0;
		end else if (cmd.step && ids_eq && (count_q != '1)) begin
			count_q <= count_q + cnc_pkg::COUNT_W'(1);
		end
		if (cmd.load_result) begin
			common_count_q <= count_q;
		end
	end

	assign common_count = common_count_q;

	`CNC_ASSERT_SAME(a_step_has_work, clk, arst_n, cmd.step, !status.merge_done, "merge step with an exhausted row")
	`CNC_ASSERT_NEXT(a_ptr_in_row, clk, arst_n, cmd.step, a_q <= ae_q && b_q <= be_q, "merge pointer ran past its row end")
	`CNC_ASSERT_NEXT(a_count_on_match, clk, arst_n, cmd.step && ids_eq && count_q != '1, count_q == $past(count_q) + cnc_pkg::COUNT_W'(1), "match not counted")

endmodule

`default_nettype wire

/* design/csr_common_neighbor_counter.sv */
// Channel   Dir  Handshake               tuser      tdata
// s_axis    in   s_axis_tvalid/_tready   cmd        load_address, load_value, src_node, dst_node
// m_axis    out  m_axis_tvalid/_tready   -          common_count
//
// A load gives no result. A query holds off the input while it runs: a lookup
// of each row in the row-start memory, then merge steps (at most the sum of the
// two row degrees), one merge step per cycle, limited by the two read ports of
// the neighbor memory.
// Both stores are undefined after reset; no clearing pass runs.
// A result waits in the output register; a query finishing while the previous
// result is still unclaimed stalls until that transfer is taken.
`default_nettype none

module csr_common_neighbor_counter #(
	parameter int MAX_NODES = cnc_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = cnc_pkg::DEF_MAX_EDGES
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// load_address[13:0], load_value[28:14], src_node[38:29], dst_node[48:39]
	input  wire logic [cnc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd[1:0]
	input  wire logic [cnc_pkg::OP_W-1:0]          s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// common_count[10:0]
	output logic      [cnc_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

	cnc_pkg::cnc_cmd_t             cmd;
	cnc_pkg::cnc_status_t          status;
	logic [cnc_pkg::COUNT_W-1:0]   common_count;

	cnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

	cnc_datapath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.load_address (s_axis_tdata[cnc_pkg::ADDR_LSB +: cnc_pkg::ADDR_W]),
		.load_value   (s_axis_tdata[cnc_pkg::VALUE_LSB +: cnc_pkg::VALUE_W]),
		.src_node     (s_axis_tdata[cnc_pkg::SRC_LSB +: cnc_pkg::NODE_W]),
		.dst_node     (s_axis_tdata[cnc_pkg::DST_LSB +: cnc_pkg::NODE_W]),
		.common_count (common_count)
	);

	// Pad the count to whole bytes
	assign m_axis_tdata = cnc_pkg::OUT_DATA_W'(common_count);

endmodule

`default_nettype wire

/* tb/sv/common_count_checker.sv */
`timescale 1ns / 100ps

module common_count_checker
	import cnc_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int MAX_EDGES = DEF_MAX_EDGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// load_address, load_value, src_node, dst_node
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic [OP_W-1:0]       s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// common_count
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int unsigned           fail_count,
	output int unsigned           counts_pending,
	output int unsigned           queries_seen
);

	localparam int unsigned COUNT_CEIL = 2 ** COUNT_W - 1;
	localparam int unsigned PRINT_CAP  = 40;

	// Own copy of both stores; entries are only read once written
	bit [VALUE_W-1:0] row_base [0:MAX_NODES];
	bit [NBR_W-1:0]   nbr_id   [0:MAX_EDGES-1];

	// Counts owed by accepted queries, oldest first
	logic [COUNT_W-1:0] counts_due [$];

	cnc_op_t             op_in;
	logic [ADDR_W-1:0]   addr_in;
	logic [VALUE_W-1:0]  value_in;
	logic [NODE_W-1:0]   src_in;
	logic [NODE_W-1:0]   dst_in;
	logic [COUNT_W-1:0]  count_want;

	function automatic int unsigned clip_edge(input int unsigned e);
		return (e > MAX_EDGES) ? MAX_EDGES : e;
	endfunction

	// Two-pointer merge over the rows of u and v
	function automatic logic [COUNT_W-1:0] shared_neighbors(input logic [NODE_W-1:0] u,
			input logic [NODE_W-1:0] v);
		int unsigned a, a_end, b, b_end, hits;
		a = 0;
		a_end = 0;
		b = 0;
		b_end = 0;
		hits = 0;
		if (u < MAX_NODES) begin
			a = clip_edge(row_base[u]);
			a_end = clip_edge(row_base[u + 1]);
		end
		if (v < MAX_NODES) begin
			b = clip_edge(row_base[v]);
			b_end = clip_edge(row_base[v + 1]);
		end
		while (a < a_end && b < b_end) begin
			if (nbr_id[a] == nbr_id[b]) begin
				if (hits < COUNT_CEIL)
					hits++;
				a++;
				b++;
			end else if (nbr_id[a] < nbr_id[b]) begin
				a++;
			end else begin
				b++;
			end
		end
		return hits[COUNT_W-1:0];
	endfunction

	task automatic flag_mismatch(input string what);
		if (fail_count < PRINT_CAP)
			$display("%0t ns: count mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Compare result transfers first, then fold in the input transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_due.delete();
			counts_pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (counts_due.size() == 0) begin
					flag_mismatch($sformatf("result %0d with no query outstanding",
						m_axis_tdata));
				end else begin
					count_want = counts_due.pop_front();
					if (m_axis_tdata[COUNT_W-1:0] !== count_want)
						flag_mismatch($sformatf("common_count got %0d, want %0d",
							m_axis_tdata[COUNT_W-1:0], count_want));
					if (m_axis_tdata[OUT_DATA_W-1:COUNT_W] !== '0)
						flag_mismatch($sformatf("padding bits not zero: %h", m_axis_tdata));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				op_in    = s_axis_tuser;
				addr_in  = s_axis_tdata[ADDR_LSB +: ADDR_W];
				value_in = s_axis_tdata[VALUE_LSB +: VALUE_W];
				src_in   = s_axis_tdata[SRC_LSB +: NODE_W];
				dst_in   = s_axis_tdata[DST_LSB +: NODE_W];
				case (op_in)
					OP_LOAD_ROW: begin
						if (addr_in <= MAX_NODES)
							row_base[addr_in] = value_in;
					end
					OP_LOAD_NBR: begin
						if (addr_in < MAX_EDGES)
							nbr_id[addr_in] = value_in[NBR_W-1:0];
					end
					OP_QUERY: begin
						counts_due.push_back(shared_neighbors(src_in, dst_in));
						queries_seen++;
					end
					default: ;
				endcase
			end
			counts_pending <= counts_due.size();
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import cnc_pkg::*;

	localparam int          NODES        = DEF_MAX_NODES;
	localparam int          EDGES        = DEF_MAX_EDGES;
	localparam int unsigned RANDOM_ITEMS = 1620;
	localparam int unsigned ROW_SPAN_CAP = 24;
	localparam int unsigned NBR_TOP      = 2 ** NBR_W - 1;
	localparam cnc_op_t     OP_UNUSED    = 2'd3;

	typedef struct {
		cnc_op_t     op;
		int unsigned addr;
		int unsigned value;
	} load_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [OP_W-1:0]       s_axis_tuser  = OP_LOAD_ROW;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int unsigned fail_count;
	int unsigned counts_pending;
	int unsigned queries_seen;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned items_sent    = 0;
	int unsigned random_start;

	// Row starts and written marks: keep every query on written entries
	bit [VALUE_W-1:0] row_shadow [0:NODES];
	bit               row_set    [0:NODES];
	bit               nbr_set    [0:EDGES-1];

	csr_common_neighbor_counter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	common_count_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.fail_count     (fail_count),
		.counts_pending (counts_pending),
		.queries_seen   (queries_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result channel at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Present one item, idling first at random, and hold it until the transfer
	task automatic send_item(input cnc_op_t op, input int unsigned addr,
			input int unsigned value, input int unsigned src, input int unsigned dst);
		logic [IN_DATA_W-1:0] word;
		int unsigned          gap;
		if (op == OP_QUERY) begin
			addr = $urandom;
			value = $urandom;
		end else if (op != OP_UNUSED) begin
			src = $urandom;
			dst = $urandom;
		end
		word = '0;
		word[ADDR_LSB +: ADDR_W]   = addr[ADDR_W-1:0];
		word[VALUE_LSB +: VALUE_W] = value[VALUE_W-1:0];
		word[SRC_LSB +: NODE_W]    = src[NODE_W-1:0];
		word[DST_LSB +: NODE_W]    = dst[NODE_W-1:0];
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_LOAD_ROW && addr[ADDR_W-1:0] <= NODES) begin
			row_shadow[addr[ADDR_W-1:0]] = value[VALUE_W-1:0];
			row_set[addr[ADDR_W-1:0]] = 1'b1;
		end
		if (op == OP_LOAD_NBR && addr[ADDR_W-1:0] < EDGES)
			nbr_set[addr[ADDR_W-1:0]] = 1'b1;
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Hold off the sender until every owed count has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (counts_pending != 0);
	endtask

	// A node may be queried only if its row lies on written, short enough storage
	function automatic bit node_usable(input int unsigned n);
		int unsigned lo, hi;
		if (!row_set[n] || !row_set[n + 1])
			return 1'b0;
		lo = (row_shadow[n] > EDGES) ? EDGES : row_shadow[n];
		hi = (row_shadow[n + 1] > EDGES) ? EDGES : row_shadow[n + 1];
		if (hi <= lo)
			return 1'b1;
		if (hi - lo > ROW_SPAN_CAP)
			return 1'b0;
		for (int unsigned e = lo; e < hi; e++)
			if (!nbr_set[e])
				return 1'b0;
		return 1'b1;
	endfunction

	// Mostly a node of the fresh graph, sometimes any usable one
	function automatic int unsigned pick_node(input int unsigned base, input int unsigned k);
		int unsigned n;
		n = $urandom_range(NODES - 1);
		if ($urandom_range(4) != 0 || !node_usable(n))
			n = base + $urandom_range(k - 1);
		return n;
	endfunction

	// Load a small graph in shuffled order, then count shared neighbors across it
	task automatic run_episode();
		load_t       loads [$];
		load_t       tmp;
		int unsigned k, base, cursor, win_lo, step, deg, id, nq, j;
		k = $urandom_range(2, 6);
		base = $urandom_range(0, NODES - k);
		cursor = $urandom_range(0, EDGES - 80);
		win_lo = $urandom_range(0, NBR_TOP - 63);
		case ($urandom_range(2))
			0: step = 1;
			1: step = 6;
			default: step = 150;
		endcase
		for (int i = 0; i < k; i++) begin
			loads.push_back('{OP_LOAD_ROW, base + i, cursor});
			deg = $urandom_range(0, 12);
			id = win_lo + $urandom_range(0, step);
			for (int d = 0; d < deg; d++) begin
				if (id > NBR_TOP)
					id = NBR_TOP;
				loads.push_back('{OP_LOAD_NBR, cursor, ($urandom_range(31) << NBR_W) | id});
				cursor++;
				// an occasional unsorted entry
				if ($urandom_range(9) == 0)
					id = win_lo + $urandom_range(0, 63);
				else
					id = id + $urandom_range(0, step);
			end
		end
		loads.push_back('{OP_LOAD_ROW, base + k, cursor});
		for (int i = loads.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = loads[i];
			loads[i] = loads[j];
			loads[j] = tmp;
		end
		foreach (loads[i])
			send_item(loads[i].op, loads[i].addr, loads[i].value, 0, 0);
		// noise: unused command and out-of-range row-start writes
		if ($urandom_range(3) == 0)
			send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(3) == 0)
			send_item(OP_LOAD_ROW, $urandom_range(NODES + 1, 2 ** ADDR_W - 1), $urandom, 0, 0);
		nq = $urandom_range(3, 10);
		for (int q = 0; q < nq; q++)
			send_item(OP_QUERY, 0, 0, pick_node(base, k), pick_node(base, k));
		if ($urandom_range(9) == 0)
			wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: two small rows sharing two ids, truncated neighbor values
		send_item(OP_LOAD_ROW, 0, 0, 0, 0);
		send_item(OP_LOAD_ROW, 1, 3, 0, 0);
		send_item(OP_LOAD_ROW, 2, 6, 0, 0);
		send_item(OP_LOAD_NBR, 0, 5, 0, 0);
		send_item(OP_LOAD_NBR, 1, 9, 0, 0);
		send_item(OP_LOAD_NBR, 2, NBR_TOP, 0, 0);
		send_item(OP_LOAD_NBR, 3, 0, 0, 0);
		send_item(OP_LOAD_NBR, 4, 'h7C09, 0, 0);
		send_item(OP_LOAD_NBR, 5, 'h7FFF, 0, 0);
		send_item(OP_QUERY, 0, 0, 0, 1);
		send_item(OP_QUERY, 0, 0, 0, 0);
		// last node: row end beyond the store, saturated, with a repeated id
		send_item(OP_LOAD_ROW, NODES - 1, EDGES - 4, 0, 0);
		send_item(OP_LOAD_ROW, NODES, 2 ** VALUE_W - 1, 0, 0);
		send_item(OP_LOAD_NBR, EDGES - 4, 9, 0, 0);
		send_item(OP_LOAD_NBR, EDGES - 3, 100, 0, 0);
		send_item(OP_LOAD_NBR, EDGES - 2, NBR_TOP, 0, 0);
		send_item(OP_LOAD_NBR, EDGES - 1, NBR_TOP, 0, 0);
		send_item(OP_QUERY, 0, 0, NODES - 1, 0);
		send_item(OP_QUERY, 0, 0, NODES - 1, NODES - 1);
		// inverted rows, one of them with its row start past the store
		send_item(OP_LOAD_ROW, 3, 2, 0, 0);
		send_item(OP_QUERY, 0, 0, 2, 0);
		send_item(OP_LOAD_ROW, NODES - 2, 17000, 0, 0);
		send_item(OP_QUERY, 0, 0, NODES - 2, NODES - 1);
		// ignored items must leave the stores alone
		send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
		send_item(OP_LOAD_ROW, NODES + 1, 0, 0, 0);
		send_item(OP_LOAD_ROW, 2 ** ADDR_W - 1, 1, 0, 0);
		send_item(OP_QUERY, 0, 0, 0, 1);
		wait_drained();

		// Random graphs under four traffic mixes
		random_start = items_sent;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 74;
				end
				default: begin
					send_idle_pct = 12;
					stall_pct = 12;
				end
			endcase
			while (items_sent - random_start < RANDOM_ITEMS * (p + 1) / 4)
				run_episode();
			wait_drained();
		end

		// Settle, then catch any stray result
		repeat (40) @(posedge clk);
		$display("Sent %0d load and query transfers; %0d pair counts checked,", items_sent,
			queries_seen);
		$display("including clipped and inverted rows, ignored items, four traffic mixes.");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Give up on a hang
	initial begin
		#(20_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
